FILE: sv/serial_frame_command_parser_defines.svh
// Assertion macros used by serial_frame_command_parser.sv.
`ifndef SERIAL_FRAME_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_FRAME_COMMAND_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define SFCP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define SFCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFCP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)

`define SFCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/sfcp_pkg.sv
package sfcp_pkg;

    localparam int FrameLen = 7;

    localparam logic [7:0] CHAR_START   = 8'h3B; // ';'
    localparam logic [7:0] CHAR_END     = 8'h3A; // ':'
    localparam logic [7:0] CHAR_CMD     = 8'h70; // 'p'
    localparam logic [7:0] CHAR_SEP     = 8'h78; // 'x'
    localparam logic [7:0] CHAR_FREQ    = 8'h66; // 'f'
    localparam logic [7:0] CHAR_OXYGEN  = 8'h6F; // 'o'
    localparam logic [7:0] CHAR_VOLUME  = 8'h76; // 'v'
    localparam logic [7:0] CHAR_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39; // '9'

    localparam logic [9:0] FREQ_MIN   = 10'd5;
    localparam logic [9:0] FREQ_MAX   = 10'd30;
    localparam logic [9:0] OXYGEN_MAX = 10'd100;
    localparam logic [9:0] VOLUME_MAX = 10'd8;

    // "#ERROR#"
    localparam logic [55:0] ERROR_TEXT = 56'h234552524F5223;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_PRESSURE = 2'd1,
        STATUS_ERROR    = 2'd2,
        STATUS_PARAM    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PARAM_FREQ   = 2'd0,
        PARAM_OXYGEN = 2'd1,
        PARAM_VOLUME = 2'd2
    } param_id_t;

    // entry 0 holds the first byte of the frame
    typedef logic [FrameLen-1:0][7:0] frame_t;

    typedef struct packed {
        status_t    status;
        logic [55:0] pressure_text;
        param_id_t  param_id;
        logic [6:0] param_value;
    } result_t;

    typedef struct packed {
        logic freq;
        logic oxygen;
        logic volume;
    } enables_t;

    // results of closing a frame with the current byte
    typedef struct packed {
        result_t cmd;
        result_t pressure;
    } close_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

FILE: sv/serial_frame_command_parser.sv
// Each accepted input word's result is registered and shows on m_tdata/m_tuser in the cycle after it.
// Throughput: one word per cycle while m_tready allows it; every input word yields exactly one result word.
// The output register lets a new word in while a result is taken in the same cycle.
// Reset (aresetn low, synchronous): parser waits for ';', enables clear to 0,
// output queue empties. The frame buffer is not cleared.
`include "serial_frame_command_parser_defines.svh"

module serial_frame_command_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [55:0] pressure_text, [57:56] param_id,
                                   // [64:58] param_value, [71:65] zero
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_FREQ_EN   = 2'd0;
    localparam logic [1:0] REG_OXYGEN_EN = 2'd1;
    localparam logic [1:0] REG_VOLUME_EN = 2'd2;

    sfcp_pkg::enables_t enables_reg;
    logic               awaiting_start_reg, awaiting_start_next;
    logic               frame_is_command_reg, frame_is_command_next;
    logic [2:0]         byte_count_reg, byte_count_next;
    sfcp_pkg::frame_t   frame_bytes_reg;
    logic               frame_write;
    sfcp_pkg::result_t  result_reg, result_next;
    logic               m_tvalid_reg;
    logic               accept;
    sfcp_pkg::close_t   close;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enables_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_FREQ_EN:   enables_reg.freq   <= pwdata[0];
                REG_OXYGEN_EN: enables_reg.oxygen <= pwdata[0];
                REG_VOLUME_EN: enables_reg.volume <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_FREQ_EN:   prdata[0] = enables_reg.freq;
            REG_OXYGEN_EN: prdata[0] = enables_reg.oxygen;
            REG_VOLUME_EN: prdata[0] = enables_reg.volume;
            default:       prdata    = '0;
        endcase
    end

    // frame checks
    sfcp_frame_check u_check (
        .frame_bytes (frame_bytes_reg),
        .rx_byte     (s_tdata),
        .enables     (enables_reg),
        .close       (close)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        awaiting_start_next   = awaiting_start_reg;
        frame_is_command_next = frame_is_command_reg;
        byte_count_next       = byte_count_reg;
        frame_write           = 1'b0;
        result_next           = '0;

        priority if (awaiting_start_reg) begin
            if (s_tdata == sfcp_pkg::CHAR_START) begin
                awaiting_start_next = 1'b0;
            end
        end else if (byte_count_reg == 3'd0) begin
            // first byte is stored whatever it is
            frame_is_command_next = (s_tdata == sfcp_pkg::CHAR_CMD);
            frame_write           = 1'b1;
            byte_count_next       = 3'd1;
        end else if (frame_is_command_reg && byte_count_reg == 3'd5) begin
            result_next         = close.cmd;
            awaiting_start_next = 1'b1;
            byte_count_next     = 3'd0;
        end else if (!frame_is_command_reg && byte_count_reg == 3'd7) begin
            result_next         = close.pressure;
            awaiting_start_next = 1'b1;
            byte_count_next     = 3'd0;
        end else if (s_tdata == sfcp_pkg::CHAR_END || s_tdata == sfcp_pkg::CHAR_START) begin
            // cut-short frame; ';' restarts collection at once
            if (!frame_is_command_reg) begin
                result_next.status        = sfcp_pkg::STATUS_ERROR;
                result_next.pressure_text = sfcp_pkg::ERROR_TEXT;
            end
            awaiting_start_next = (s_tdata == sfcp_pkg::CHAR_END);
            byte_count_next     = 3'd0;
        end else begin
            frame_write     = 1'b1;
            byte_count_next = byte_count_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_start_reg   <= 1'b1;
            frame_is_command_reg <= 1'b0;
            byte_count_reg       <= '0;
        end else if (accept) begin
            awaiting_start_reg   <= awaiting_start_next;
            frame_is_command_reg <= frame_is_command_next;
            byte_count_reg       <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && frame_write) begin
            frame_bytes_reg[byte_count_reg] <= s_tdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {7'd0, result_reg.param_value, result_reg.param_id,
                       result_reg.pressure_text};

    `SFCP_ASSERT_IMPL(a_idle_count_zero, aclk, aresetn, awaiting_start_reg,
                      byte_count_reg == 3'd0, "byte count not cleared while waiting for start")

    `SFCP_ASSERT_IMPL(a_cmd_count_bound, aclk, aresetn, frame_is_command_reg && !awaiting_start_reg,
                      byte_count_reg <= 3'd5, "command frame grew past its length")

    `SFCP_ASSERT_IMPL(a_error_text, aclk, aresetn,
                      m_tvalid_reg && result_reg.status == sfcp_pkg::STATUS_ERROR,
                      result_reg.pressure_text == sfcp_pkg::ERROR_TEXT, "error word lacks error text")

    `SFCP_ASSERT_IMPL(a_param_range, aclk, aresetn,
                      m_tvalid_reg && result_reg.status == sfcp_pkg::STATUS_PARAM,
                      result_reg.param_value <= 7'd100, "parameter value out of range")

    `SFCP_ASSERT_NEXT(a_close_returns_idle, aclk, aresetn,
                      accept && !awaiting_start_reg && !frame_is_command_reg
                      && byte_count_reg == 3'd7,
                      awaiting_start_reg && m_tvalid_reg
                      && (result_reg.status == sfcp_pkg::STATUS_PRESSURE
                          || result_reg.status == sfcp_pkg::STATUS_ERROR),
                      "full pressure frame did not close")

endmodule

FILE: sv/sfcp_frame_check.sv
module sfcp_frame_check (
    input  sfcp_pkg::frame_t   frame_bytes,
    input  logic [7:0]         rx_byte,
    input  sfcp_pkg::enables_t enables,
    output sfcp_pkg::close_t   close
);

    logic       press_ok;
    logic       cmd_ok;
    logic [3:0] d_hi;
    logic [3:0] d_mid;
    logic [3:0] d_lo;
    logic [9:0] value;
    logic [7:0] letter;

    always_comb begin
        press_ok = (rx_byte == sfcp_pkg::CHAR_END) && (frame_bytes[3] == sfcp_pkg::CHAR_SEP);
        for (int i = 0; i < 3; i++) begin
            press_ok = press_ok && sfcp_pkg::is_digit(frame_bytes[i])
                       && sfcp_pkg::is_digit(frame_bytes[i+4]);
        end

        cmd_ok = (rx_byte == sfcp_pkg::CHAR_END) && (frame_bytes[0] == sfcp_pkg::CHAR_CMD)
                 && sfcp_pkg::is_digit(frame_bytes[2]) && sfcp_pkg::is_digit(frame_bytes[3])
                 && sfcp_pkg::is_digit(frame_bytes[4]);

        d_hi   = 4'(frame_bytes[2] - sfcp_pkg::CHAR_ZERO);
        d_mid  = 4'(frame_bytes[3] - sfcp_pkg::CHAR_ZERO);
        d_lo   = 4'(frame_bytes[4] - sfcp_pkg::CHAR_ZERO);
        value  = 10'(d_hi) * 10'd100 + 10'(d_mid) * 10'd10 + 10'(d_lo);
        letter = frame_bytes[1];
    end

    always_comb begin
        close.pressure = '0;
        if (press_ok) begin
            close.pressure.status        = sfcp_pkg::STATUS_PRESSURE;
            close.pressure.pressure_text = {frame_bytes[0], frame_bytes[1], frame_bytes[2],
                                            frame_bytes[3], frame_bytes[4], frame_bytes[5],
                                            frame_bytes[6]};
        end else begin
            close.pressure.status        = sfcp_pkg::STATUS_ERROR;
            close.pressure.pressure_text = sfcp_pkg::ERROR_TEXT;
        end

        // drop malformed frames, unknown letters, disabled parameters and out-of-range values
        close.cmd = '0;
        if (cmd_ok) begin
            if (letter == sfcp_pkg::CHAR_FREQ && enables.freq
                && value >= sfcp_pkg::FREQ_MIN && value <= sfcp_pkg::FREQ_MAX) begin
                close.cmd.status      = sfcp_pkg::STATUS_PARAM;
                close.cmd.param_id    = sfcp_pkg::PARAM_FREQ;
                close.cmd.param_value = value[6:0];
            end
            if (letter == sfcp_pkg::CHAR_OXYGEN && enables.oxygen
                && value <= sfcp_pkg::OXYGEN_MAX) begin
                close.cmd.status      = sfcp_pkg::STATUS_PARAM;
                close.cmd.param_id    = sfcp_pkg::PARAM_OXYGEN;
                close.cmd.param_value = value[6:0];
            end
            if (letter == sfcp_pkg::CHAR_VOLUME && enables.volume
                && value <= sfcp_pkg::VOLUME_MAX) begin
                close.cmd.status      = sfcp_pkg::STATUS_PARAM;
                close.cmd.param_id    = sfcp_pkg::PARAM_VOLUME;
                close.cmd.param_value = value[6:0];
            end
        end
    end

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] ADDR_FREQ_EN   = 4'h0;
    localparam logic [3:0] ADDR_OXYGEN_EN = 4'h4;
    localparam logic [3:0] ADDR_VOLUME_EN = 4'h8;
    localparam logic [3:0] ADDR_UNUSED    = 4'hC;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    serial_frame_command_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // parser state mirrored from the accepted input words
    logic       wait_sync = 1'b1;
    logic       cmd_frame = 1'b0;
    logic [2:0] frame_cnt = 3'd0;
    logic [7:0] frame_buf [7];
    logic       en_freq   = 1'b0;
    logic       en_oxygen = 1'b0;
    logic       en_volume = 1'b0;

    sfcp_pkg::result_t pending_results [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    int      hold_request = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic ascii_digit(input logic [7:0] c);
        return c >= sfcp_pkg::CHAR_ZERO && c <= sfcp_pkg::CHAR_NINE;
    endfunction

    function automatic sfcp_pkg::result_t parse_byte(input logic [7:0] b);
        sfcp_pkg::result_t r;
        int      num;
        r = '0;
        if (wait_sync) begin
            if (b == sfcp_pkg::CHAR_START)
                wait_sync = 1'b0;
        end else if (frame_cnt == 3'd0) begin
            cmd_frame = (b == sfcp_pkg::CHAR_CMD);
            frame_buf[0] = b;
            frame_cnt = 3'd1;
        end else if (cmd_frame && frame_cnt == 3'd5) begin
            if (b == sfcp_pkg::CHAR_END && frame_buf[0] == sfcp_pkg::CHAR_CMD &&
                ascii_digit(frame_buf[2]) && ascii_digit(frame_buf[3]) &&
                ascii_digit(frame_buf[4])) begin
                num = (int'(frame_buf[2]) - int'(sfcp_pkg::CHAR_ZERO)) * 100 +
                      (int'(frame_buf[3]) - int'(sfcp_pkg::CHAR_ZERO)) * 10 +
                      (int'(frame_buf[4]) - int'(sfcp_pkg::CHAR_ZERO));
                if (frame_buf[1] == sfcp_pkg::CHAR_FREQ && en_freq) begin
                    if (num >= int'(sfcp_pkg::FREQ_MIN) && num <= int'(sfcp_pkg::FREQ_MAX)) begin
                        r.status = sfcp_pkg::STATUS_PARAM;
                        r.param_id = sfcp_pkg::PARAM_FREQ;
                        r.param_value = num[6:0];
                    end
                end else if (frame_buf[1] == sfcp_pkg::CHAR_OXYGEN && en_oxygen) begin
                    if (num <= int'(sfcp_pkg::OXYGEN_MAX)) begin
                        r.status = sfcp_pkg::STATUS_PARAM;
                        r.param_id = sfcp_pkg::PARAM_OXYGEN;
                        r.param_value = num[6:0];
                    end
                end else if (frame_buf[1] == sfcp_pkg::CHAR_VOLUME && en_volume) begin
                    if (num <= int'(sfcp_pkg::VOLUME_MAX)) begin
                        r.status = sfcp_pkg::STATUS_PARAM;
                        r.param_id = sfcp_pkg::PARAM_VOLUME;
                        r.param_value = num[6:0];
                    end
                end
            end
            wait_sync = 1'b1;
            frame_cnt = 3'd0;
        end else if (!cmd_frame && frame_cnt == 3'd7) begin
            if (b == sfcp_pkg::CHAR_END && frame_buf[3] == sfcp_pkg::CHAR_SEP &&
                ascii_digit(frame_buf[0]) && ascii_digit(frame_buf[1]) &&
                ascii_digit(frame_buf[2]) && ascii_digit(frame_buf[4]) &&
                ascii_digit(frame_buf[5]) && ascii_digit(frame_buf[6])) begin
                r.status = sfcp_pkg::STATUS_PRESSURE;
                r.pressure_text = {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3],
                                   frame_buf[4], frame_buf[5], frame_buf[6]};
            end else begin
                r.status = sfcp_pkg::STATUS_ERROR;
                r.pressure_text = sfcp_pkg::ERROR_TEXT;
            end
            wait_sync = 1'b1;
            frame_cnt = 3'd0;
        end else if (b == sfcp_pkg::CHAR_END) begin
            if (!cmd_frame) begin
                r.status = sfcp_pkg::STATUS_ERROR;
                r.pressure_text = sfcp_pkg::ERROR_TEXT;
            end
            wait_sync = 1'b1;
            frame_cnt = 3'd0;
        end else if (b == sfcp_pkg::CHAR_START) begin
            // restart collection with the next word
            if (!cmd_frame) begin
                r.status = sfcp_pkg::STATUS_ERROR;
                r.pressure_text = sfcp_pkg::ERROR_TEXT;
            end
            frame_cnt = 3'd0;
        end else begin
            frame_buf[frame_cnt] = b;
            frame_cnt = frame_cnt + 3'd1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_results.push_back(parse_byte(s_tdata));
    end

    always @(posedge aclk) begin
        sfcp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d data %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[55:0] !== want.pressure_text) begin
                    $error("pressure_text: expected %h, actual %h",
                           want.pressure_text, m_tdata[55:0]);
                    fail_count++;
                end
                if (m_tdata[57:56] !== want.param_id) begin
                    $error("param_id: expected %0d, actual %0d", want.param_id, m_tdata[57:56]);
                    fail_count++;
                end
                if (m_tdata[64:58] !== want.param_value) begin
                    $error("param_value: expected %0d, actual %0d",
                           want.param_value, m_tdata[64:58]);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // valid stays high after a handshake; the next call either reuses it or idles first
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // let the last accepted word reach the queue first
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic value);
        logic [31:0] data;
        data = $urandom();
        data[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (addr)
            ADDR_FREQ_EN:   en_freq = value;
            ADDR_OXYGEN_EN: en_oxygen = value;
            ADDR_VOLUME_EN: en_volume = value;
            default: ;
        endcase
    endtask

    // bit 0 freq, bit 1 oxygen, bit 2 volume
    task automatic set_enables(input logic [2:0] en);
        write_reg(ADDR_FREQ_EN, en[0]);
        write_reg(ADDR_OXYGEN_EN, en[1]);
        write_reg(ADDR_VOLUME_EN, en[2]);
    endtask

    function automatic logic [23:0] digits3(input int v);
        return {sfcp_pkg::CHAR_ZERO + 8'(v / 100), sfcp_pkg::CHAR_ZERO + 8'((v / 10) % 10),
                sfcp_pkg::CHAR_ZERO + 8'(v % 10)};
    endfunction

    function automatic int pick_value();
        int boundary_vals [13] = '{0, 4, 5, 6, 8, 9, 29, 30, 31, 99, 100, 101, 999};
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 999);
            1:       return $urandom_range(0, 120);
            default: return boundary_vals[$urandom_range(0, 12)];
        endcase
    endfunction

    task automatic test_commands_disabled();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text(";pf010:;po050:;pv004:;123x456:");
        wait_drained();
    endtask

    task automatic test_enable_select();
        write_reg(ADDR_UNUSED, 1'b1);
        set_enables(3'b010);
        send_text(";pf010:;po050:;pv004:");
        wait_drained();
        set_enables(3'b101);
        send_text(";pf010:;po050:;pv004:");
        wait_drained();
        set_enables(3'b111);
    endtask

    task automatic test_command_ranges();
        send_text(";pf005:;pf030:;pf004:;pf031:;pf999:;po000:;po100:;po101:");
        send_text(";pv000:;pv008:;pv009:;pq010:;pf0/5:;pfA10:");
        // cut short by ':' and ';', and a wrong closing word
        send_text(";pf0:;pf;123x456:;pf0101;pv003:");
        wait_drained();
    endtask

    task automatic test_pressure_frames();
        send_text(";123x456:;000x999:;999x999:;12:;12;345x678:");
        // first word of a frame is stored even when it is a delimiter
        send_text(";;23x456:;:23x456:;123x456;;123y456:;12/x456:;123x45::");
        send_byte(sfcp_pkg::CHAR_START);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("3x456:");
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 300;
        for (int i = 0; i < 6; i++)
            send_text(";321x654:");
        wait_drained();
    endtask

    task automatic send_random_frames(input int n_words);
        logic [7:0]  fr [$];
        logic [23:0] d;
        int          sent;
        int          kind;
        int          pos;
        sent = 0;
        while (sent < n_words) begin
            fr.delete();
            // junk words with the top bit set, ignored while waiting for the start word
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)) | 8'h80);
            kind = $urandom_range(0, 99);
            if (kind < 45 || (kind >= 80 && kind < 90)) begin
                fr.push_back(sfcp_pkg::CHAR_START);
                d = digits3($urandom_range(0, 999));
                fr.push_back(d[23:16]); fr.push_back(d[15:8]); fr.push_back(d[7:0]);
                fr.push_back(sfcp_pkg::CHAR_SEP);
                d = digits3($urandom_range(0, 999));
                fr.push_back(d[23:16]); fr.push_back(d[15:8]); fr.push_back(d[7:0]);
                fr.push_back(sfcp_pkg::CHAR_END);
            end else if (kind < 80) begin
                fr.push_back(sfcp_pkg::CHAR_START);
                fr.push_back(sfcp_pkg::CHAR_CMD);
                case ($urandom_range(0, 9))
                    0, 1, 2: fr.push_back(sfcp_pkg::CHAR_FREQ);
                    3, 4, 5: fr.push_back(sfcp_pkg::CHAR_OXYGEN);
                    6, 7, 8: fr.push_back(sfcp_pkg::CHAR_VOLUME);
                    default: fr.push_back(8'($urandom_range(0, 255)));
                endcase
                d = digits3(pick_value());
                fr.push_back(d[23:16]); fr.push_back(d[15:8]); fr.push_back(d[7:0]);
                fr.push_back(sfcp_pkg::CHAR_END);
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    case ($urandom_range(0, 5))
                        0:       fr.push_back(sfcp_pkg::CHAR_START);
                        1:       fr.push_back(sfcp_pkg::CHAR_END);
                        default: fr.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            if (kind >= 80 && kind < 90) begin
                // truncate: the next start word lands mid-frame
                pos = $urandom_range(2, 7);
                while (fr.size() > pos) void'(fr.pop_back());
            end else if (kind < 80 && $urandom_range(0, 5) == 0) begin
                pos = $urandom_range(1, fr.size() - 1);
                fr[pos] = 8'($urandom_range(0, 255));
            end
            foreach (fr[i])
                send_byte(fr[i]);
            sent += fr.size();
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            if (ph == 0)
                set_enables(3'b111);
            else if (ph == 1)
                set_enables(3'b000);
            else
                set_enables(3'($urandom_range(0, 7)));
            idle_on = (ph < 7);
            send_random_frames(165);
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_commands_disabled();
        test_enable_select();
        test_command_ranges();
        test_pressure_frames();
        test_output_backpressure();
        test_random_traffic();
        repeat (5) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/sfcp_pkg.sv
sv/sfcp_frame_check.sv
sv/serial_frame_command_parser.sv
sim/tb.sv
